@@ src/yprc_pkg.sv @@
// ----------------------------------------------------------------------------
// yprc_pkg
// Types, codes and fixed-point constants of the yaw PI rotation controller.
// ----------------------------------------------------------------------------
package yprc_pkg;

	localparam int TIMEOUT_LIMIT_DEF = 3;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_OFFSET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd4;

	// register reset values
	localparam logic [15:0] MAX_RATE_RST    = 16'd8192;
	localparam logic [15:0] TURN_OFFSET_RST = 16'd0;
	localparam logic [14:0] TOLERANCE_RST   = 15'd82;
	localparam logic [15:0] PROP_GAIN_RST   = 16'd256;
	localparam logic [15:0] INTEG_GAIN_RST  = 16'd0;

	// item function codes
	localparam logic FUNC_MEAS    = 1'b0;
	localparam logic FUNC_TIMEOUT = 1'b1;

	// angles are 1/8192 rad per LSB; raw error is 18 bits wide
	localparam logic signed [17:0] ANG_PI     = 18'sd25736;
	localparam logic signed [17:0] ANG_NEG_PI = -18'sd25736;
	localparam logic signed [17:0] ANG_TWO_PI = 18'sd51472;

	// 0.033 in signed Q0.16
	localparam logic signed [16:0] INTEG_STEP = 17'sd2163;

	// half of the 2^24 output scale, for round half up
	localparam logic signed [49:0] ROUND_HALF = 50'sd8388608;

	localparam logic signed [31:0] INTEG_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] INTEG_MIN = 32'sh8000_0000;

	typedef enum logic [1:0] {
		STAT_RUN     = 2'd0,
		STAT_SUCCESS = 2'd1,
		STAT_FAIL    = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRAP,
		ST_MUL_I,
		ST_ACC_I,
		ST_MUL_P,
		ST_MUL_K,
		ST_SUM,
		ST_CLAMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic        [15:0] max_rate;
		logic signed [15:0] turn_offset;
		logic        [14:0] tolerance;
		logic        [15:0] prop_gain;
		logic        [15:0] integ_gain;
	} cfg_t;

endpackage

@@ src/yprc_item_if.sv @@
// ----------------------------------------------------------------------------
// yprc_item_if
// Input channel: one yaw measurement or timeout tick per word.
// ----------------------------------------------------------------------------
interface yprc_item_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic signed [15:0] yaw;

	modport source (output valid, output func, output yaw, input ready);
	modport sink (input valid, input func, input yaw, output ready);
endinterface

@@ src/yprc_result_if.sv @@
// ----------------------------------------------------------------------------
// yprc_result_if
// Result channel: status and turn-rate command, one word per input word.
// ----------------------------------------------------------------------------
interface yprc_result_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  status;
	logic               drive_valid;
	logic signed [16:0] drive;

	modport source (output valid, output status, output drive_valid, output drive,
		input ready);
	modport sink (input valid, input status, input drive_valid, input drive,
		output ready);
endinterface

@@ src/yprc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// yprc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface yprc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [yprc_pkg::CFG_IDX_W-1:0]  index;
	logic [yprc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/yprc_cfg.sv @@
// ----------------------------------------------------------------------------
// yprc_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module yprc_cfg (
	input  logic           clk,
	input  logic           arst_n,
	yprc_cfg_if.sink       cfg,
	output yprc_pkg::cfg_t regs
);

	yprc_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.max_rate    <= yprc_pkg::MAX_RATE_RST;
			regs_q.turn_offset <= yprc_pkg::TURN_OFFSET_RST;
			regs_q.tolerance   <= yprc_pkg::TOLERANCE_RST;
			regs_q.prop_gain   <= yprc_pkg::PROP_GAIN_RST;
			regs_q.integ_gain  <= yprc_pkg::INTEG_GAIN_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				yprc_pkg::REG_MAX_RATE:    regs_q.max_rate    <= cfg.data;
				yprc_pkg::REG_TURN_OFFSET: regs_q.turn_offset <= cfg.data;
				yprc_pkg::REG_TOLERANCE:   regs_q.tolerance   <= cfg.data[14:0];
				yprc_pkg::REG_PROP_GAIN:   regs_q.prop_gain   <= cfg.data;
				yprc_pkg::REG_INTEG_GAIN:  regs_q.integ_gain  <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

@@ src/yprc_mul.sv @@
// ----------------------------------------------------------------------------
// yprc_mul
// Shared signed 32x17 multiplier with a registered product.
// ----------------------------------------------------------------------------
module yprc_mul (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [16:0] b,
	output logic signed [48:0] prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

endmodule

@@ src/yaw_pi_rotation_controller.sv @@
// ----------------------------------------------------------------------------
// yaw_pi_rotation_controller
// PI turn-rate controller toward a relative yaw goal, with angle wrap.
//
// Channels: item (func, yaw) in, result (status, drive_valid, drive) out,
// cfg writes registers 0..4 (max_rate, turn_offset, tolerance, prop_gain,
// integ_gain); cfg is always ready and should be written only while idle.
// Every input word yields exactly one result word.
// A small sequencer runs one shared 32x17 multiplier for the integral step
// and, when a measurement issues a command, the proportional and integral
// terms, with one add/sub per cycle for the angle wrap.
// A timeout tick goes from idle straight to done; a measurement runs the
// wrap and the integral step, then done if it reaches the goal, else sum and clamp.
// The item channel is ready only in the idle state, so no new word is
// accepted until the sequencer is back in idle.
// The finished word sits in an output register; the next word is accepted
// while it waits, but a further result holds in the sequencer until the
// receiver takes the one before it.
// Reset clears the goal, the integral, the miss count and the registers to
// their defaults; no result is pending after reset.
// ----------------------------------------------------------------------------
module yaw_pi_rotation_controller #(
	parameter int TIMEOUT_LIMIT = yprc_pkg::TIMEOUT_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	yprc_item_if.sink   item,
	yprc_result_if.source result,
	yprc_cfg_if.sink    cfg
);

	localparam logic [1:0] MISS_LIMIT = 2'(TIMEOUT_LIMIT);

	yprc_pkg::cfg_t   regs;
	yprc_pkg::state_t state_q, state_d;

	logic                goal_set_q;
	logic signed [16:0]  goal_q;
	logic signed [31:0]  integ_q;
	logic [1:0]          miss_q;
	logic signed [17:0]  err_q;
	logic signed [49:0]  sum_q;

	yprc_pkg::status_t   res_status_q;
	logic                res_dv_q;
	logic signed [16:0]  res_drive_q;

	logic                out_valid_q;
	yprc_pkg::status_t   out_status_q;
	logic                out_dv_q;
	logic signed [16:0]  out_drive_q;

	logic signed [31:0]  mul_a;
	logic signed [16:0]  mul_b;
	logic signed [48:0]  prod_s1;

	logic signed [16:0]  goal_new;
	logic signed [16:0]  goal_sel;
	logic signed [17:0]  err_new;
	logic [1:0]          miss_nx;
	logic signed [33:0]  acc;
	logic signed [31:0]  acc_sat;
	logic [15:0]         err_mag;
	logic signed [25:0]  rate;
	logic signed [25:0]  max_ext;
	logic signed [16:0]  drive_clamp;
	logic                out_free;

	yprc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	yprc_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (prod_s1)
	);

	assign result.valid       = out_valid_q;
	assign result.status      = out_status_q;
	assign result.drive_valid = out_dv_q;
	assign result.drive       = out_drive_q;

	assign out_free = !out_valid_q || result.ready;

	// goal latch and raw error
	assign goal_new = 17'(item.yaw) + 17'(regs.turn_offset);
	assign goal_sel = goal_set_q ? goal_q : goal_new;
	assign err_new  = 18'(goal_sel) - 18'(item.yaw);
	assign miss_nx  = miss_q + 2'd1;

	// integral step with saturation
	assign acc = 34'(integ_q) + 34'(prod_s1);
	always_comb begin
		if (!acc[33] && (acc[32:31] != 2'b00)) begin
			acc_sat = yprc_pkg::INTEG_MAX;
		end else if (acc[33] && (acc[32:31] != 2'b11)) begin
			acc_sat = yprc_pkg::INTEG_MIN;
		end else begin
			acc_sat = acc[31:0];
		end
	end

	assign err_mag = err_q[17] ? 16'(-err_q) : err_q[15:0];

	// rate clamp
	assign rate    = sum_q[49:24];
	assign max_ext = 26'(regs.max_rate);
	always_comb begin
		if (rate > max_ext) begin
			drive_clamp = 17'(max_ext);
		end else if (rate < -max_ext) begin
			drive_clamp = 17'(-max_ext);
		end else begin
			drive_clamp = rate[16:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= yprc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		mul_a      = 32'(err_q);
		mul_b      = yprc_pkg::INTEG_STEP;
		case (state_q)
			yprc_pkg::ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					state_d = (item.func == yprc_pkg::FUNC_TIMEOUT) ?
						yprc_pkg::ST_DONE : yprc_pkg::ST_WRAP;
				end
			end
			yprc_pkg::ST_WRAP: begin
				if ((err_q <= yprc_pkg::ANG_PI) && (err_q >= yprc_pkg::ANG_NEG_PI)) begin
					state_d = yprc_pkg::ST_MUL_I;
				end
			end
			yprc_pkg::ST_MUL_I: begin
				state_d = yprc_pkg::ST_ACC_I;
			end
			yprc_pkg::ST_ACC_I: begin
				state_d = (err_mag <= 16'(regs.tolerance)) ?
					yprc_pkg::ST_DONE : yprc_pkg::ST_MUL_P;
			end
			yprc_pkg::ST_MUL_P: begin
				mul_b   = 17'(regs.prop_gain);
				state_d = yprc_pkg::ST_MUL_K;
			end
			yprc_pkg::ST_MUL_K: begin
				mul_a   = integ_q;
				mul_b   = 17'(regs.integ_gain);
				state_d = yprc_pkg::ST_SUM;
			end
			yprc_pkg::ST_SUM: begin
				state_d = yprc_pkg::ST_CLAMP;
			end
			yprc_pkg::ST_CLAMP: begin
				state_d = yprc_pkg::ST_DONE;
			end
			yprc_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = yprc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = yprc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_set_q   <= 1'b0;
			goal_q       <= '0;
			integ_q      <= '0;
			miss_q       <= '0;
			err_q        <= '0;
			sum_q        <= '0;
			res_status_q <= yprc_pkg::STAT_RUN;
			res_dv_q     <= 1'b0;
			res_drive_q  <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= yprc_pkg::STAT_RUN;
			out_dv_q     <= 1'b0;
			out_drive_q  <= '0;
		end else begin
			// load a finished word, else drop the one the receiver took
			if ((state_q == yprc_pkg::ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				yprc_pkg::ST_IDLE: begin
					if (item.valid) begin
						res_dv_q    <= 1'b0;
						res_drive_q <= '0;
						if (item.func == yprc_pkg::FUNC_TIMEOUT) begin
							if (miss_nx >= MISS_LIMIT) begin
								miss_q       <= '0;
								integ_q      <= '0;
								res_status_q <= yprc_pkg::STAT_FAIL;
							end else begin
								miss_q       <= miss_nx;
								res_status_q <= yprc_pkg::STAT_RUN;
							end
						end else begin
							miss_q <= '0;
							err_q  <= err_new;
							if (!goal_set_q) begin
								integ_q    <= '0;
								goal_q     <= goal_new;
								goal_set_q <= 1'b1;
							end
						end
					end
				end
				yprc_pkg::ST_WRAP: begin
					if (err_q > yprc_pkg::ANG_PI) begin
						err_q <= err_q - yprc_pkg::ANG_TWO_PI;
					end else if (err_q < yprc_pkg::ANG_NEG_PI) begin
						err_q <= err_q + yprc_pkg::ANG_TWO_PI;
					end
				end
				yprc_pkg::ST_ACC_I: begin
					integ_q <= acc_sat;
					if (err_mag <= 16'(regs.tolerance)) begin
						goal_set_q   <= 1'b0;
						res_status_q <= yprc_pkg::STAT_SUCCESS;
					end
				end
				yprc_pkg::ST_MUL_K: begin
					// proportional term, scaled up by 2^16 to meet the integral term
					sum_q <= {prod_s1[33:0], 16'd0};
				end
				yprc_pkg::ST_SUM: begin
					sum_q <= sum_q + 50'(prod_s1) + yprc_pkg::ROUND_HALF;
				end
				yprc_pkg::ST_CLAMP: begin
					res_status_q <= yprc_pkg::STAT_RUN;
					res_dv_q     <= 1'b1;
					res_drive_q  <= drive_clamp;
				end
				yprc_pkg::ST_DONE: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_dv_q     <= res_dv_q;
						out_drive_q  <= res_drive_q;
					end
				end
				default: ;
			endcase
		end
	end

	// a new result word only comes out of the done state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == yprc_pkg::ST_DONE))
		else $error("result word raised outside the done state");

	// the goal is dropped only on success
	a_goal_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(goal_set_q) |-> (res_status_q == yprc_pkg::STAT_SUCCESS))
		else $error("goal cleared without success");

	// a turn command always carries running status
	a_cmd_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_dv_q) |-> (out_status_q == yprc_pkg::STAT_RUN))
		else $error("turn command with non-running status");

	// the miss count is cleared on reaching the limit
	a_miss_bound: assert property (@(posedge clk) disable iff (!arst_n)
		miss_q < MISS_LIMIT)
		else $error("miss count at or above limit");

endmodule

@@ tb/tb_yaw_pi_rotation_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yaw_pi_rotation_controller
// Self-checking bench for the yaw PI rotation controller. A scoreboard keeps
// its own goal, integral and miss count. It predicts status and turn-rate
// command for every accepted word and checks results in order. The stimulus
// is a directed opening and then random phases under several register
// settings, with random idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
package yprc_tb_pkg;
	import yprc_pkg::*;

	typedef struct packed {
		status_t            status;
		logic               drive_valid;
		logic signed [16:0] drive;
	} turn_cmd_t;

	class turn_cmd_scoreboard;
		logic        [15:0] max_rate;
		logic signed [15:0] turn_offset;
		logic        [14:0] tolerance;
		logic        [15:0] prop_gain;
		logic        [15:0] integ_gain;
		bit                 goal_set;
		logic signed [16:0] goal_angle;
		logic signed [31:0] integral_sum;
		logic        [1:0]  miss_count;
		turn_cmd_t          expected_cmds[$];
		int mismatches, n_writes, n_meas, n_tick, n_cmd, n_clamp, n_reached, n_failed;
		int n_wrap, n_sat;

		function new();
			max_rate = MAX_RATE_RST;
			turn_offset = TURN_OFFSET_RST;
			tolerance = TOLERANCE_RST;
			prop_gain = PROP_GAIN_RST;
			integ_gain = INTEG_GAIN_RST;
			goal_set = 1'b0;
			goal_angle = '0;
			integral_sum = '0;
			miss_count = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			n_writes++;
			case (idx)
				REG_MAX_RATE: max_rate = value;
				REG_TURN_OFFSET: turn_offset = value;
				REG_TOLERANCE: tolerance = value[14:0];
				REG_PROP_GAIN: prop_gain = value;
				REG_INTEG_GAIN: integ_gain = value;
				default: ;
			endcase
		endfunction

		// predict the result word of one accepted input word
		function void note_sample(logic func, logic signed [15:0] yaw);
			turn_cmd_t cmd;
			longint err, acc, sum, rate;
			cmd = '{STAT_RUN, 1'b0, 17'sd0};
			if (func == FUNC_TIMEOUT) begin
				n_tick++;
				miss_count = miss_count + 2'd1;
				if (miss_count >= TIMEOUT_LIMIT_DEF) begin
					miss_count = '0;
					integral_sum = '0;
					cmd.status = STAT_FAIL;
					n_failed++;
				end
			end else begin
				n_meas++;
				miss_count = '0;
				if (!goal_set) begin
					integral_sum = '0;
					goal_angle = yaw + turn_offset;
					goal_set = 1'b1;
				end
				err = longint'(goal_angle) - longint'(yaw);
				if (err > ANG_PI || err < ANG_NEG_PI)
					n_wrap++;
				// exactly +-pi is left alone
				while (err > ANG_PI)
					err -= ANG_TWO_PI;
				while (err < ANG_NEG_PI)
					err += ANG_TWO_PI;
				acc = longint'(integral_sum) + err * INTEG_STEP;
				if (acc > INTEG_MAX || acc < INTEG_MIN)
					n_sat++;
				if (acc > INTEG_MAX)
					acc = INTEG_MAX;
				if (acc < INTEG_MIN)
					acc = INTEG_MIN;
				integral_sum = acc[31:0];
				if ((err < 0 ? -err : err) <= longint'(tolerance)) begin
					goal_set = 1'b0;
					cmd.status = STAT_SUCCESS;
					n_reached++;
				end else begin
					sum = err * longint'(prop_gain) * 65536
						+ longint'(integral_sum) * longint'(integ_gain);
					// arithmetic shift gives the floor, so this rounds half up
					rate = (sum + ROUND_HALF) >>> 24;
					if (rate > longint'(max_rate) || rate < -longint'(max_rate))
						n_clamp++;
					if (rate > longint'(max_rate))
						rate = longint'(max_rate);
					if (rate < -longint'(max_rate))
						rate = -longint'(max_rate);
					cmd.drive_valid = 1'b1;
					cmd.drive = rate[16:0];
					n_cmd++;
				end
			end
			expected_cmds.push_back(cmd);
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= 50)
				$display("[%0t] ERROR %s", $time, what);
		endtask

		task check_command(logic [1:0] status, logic drive_valid, logic signed [16:0] drive);
			turn_cmd_t want;
			if (expected_cmds.size() == 0) begin
				report($sformatf("result with nothing outstanding: status %0d drive_valid %0b drive %0d",
					status, drive_valid, drive));
			end else begin
				want = expected_cmds.pop_front();
				if (status !== want.status)
					report($sformatf("status %0d, expected %0d", status, want.status));
				if (drive_valid !== want.drive_valid)
					report($sformatf("drive_valid %0b, expected %0b", drive_valid, want.drive_valid));
				if (drive !== want.drive)
					report($sformatf("drive %0d, expected %0d", drive, want.drive));
			end
		endtask
	endclass
endpackage

module tb_yaw_pi_rotation_controller;
	import yprc_pkg::*;
	import yprc_tb_pkg::*;

	localparam int HOLD_OFF_CYCLES = 400;
	localparam int ITEMS_PER_PHASE = 110;
	localparam int PUSH_RUN = 52;
	localparam int SETTLE_CYCLES = 24;

	logic clk;
	logic arst_n;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int push_sign = 1;
	turn_cmd_scoreboard sb = new();

	yprc_item_if item_ch();
	yprc_result_if res_ch();
	yprc_cfg_if cfg_ch();

	yaw_pi_rotation_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(res_ch),
		.cfg(cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.write_reg(cfg_ch.index, cfg_ch.data);
			if (item_ch.valid && item_ch.ready)
				sb.note_sample(item_ch.func, item_ch.yaw);
			if (res_ch.valid && res_ch.ready)
				sb.check_command(res_ch.status, res_ch.drive_valid, res_ch.drive);
		end
	end

	// receiver: random stalls, plus a counted hold-off on request
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// call at a falling edge; leaves valid high so back-to-back words need no gap
	task automatic send_item(input logic func, input logic signed [15:0] yaw);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.func <= func;
		item_ch.yaw <= yaw;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		item_ch.valid <= 1'b0;
		do @(negedge clk); while (sb.expected_cmds.size() != 0);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	task automatic load_settings(input logic [15:0] rate_lim, input logic [15:0] offset,
		input logic [15:0] tol, input logic [15:0] kp, input logic [15:0] ki);
		cfg_write(REG_MAX_RATE, rate_lim);
		cfg_write(REG_TURN_OFFSET, offset);
		cfg_write(REG_TOLERANCE, tol);
		cfg_write(REG_PROP_GAIN, kp);
		cfg_write(REG_INTEG_GAIN, ki);
		// an index past the register list must be dropped
		cfg_write(REG_INTEG_GAIN + 3'(1 + $urandom_range(0, 2)), 16'($urandom));
		cfg_ch.valid <= 1'b0;
	endtask

	// aim the error at the interesting spots around the latched goal
	function automatic logic signed [15:0] pick_yaw(input bit push);
		longint g, e, tol;
		int r;
		r = $urandom_range(99);
		if (!sb.goal_set || (!push && r < 12))
			return 16'($urandom);
		g = sb.goal_angle;
		tol = sb.tolerance;
		if (push) begin
			e = push_sign * longint'($urandom_range(20000, 25736));
		end else if (r < 30) begin
			e = tol + longint'($urandom_range(0, 1));
			if ($urandom_range(1))
				e = -e;
		end else if (r < 45) begin
			e = longint'($urandom_range(0, 2 * tol)) - tol;
		end else if (r < 55) begin
			e = longint'(ANG_PI) + longint'($urandom_range(0, 1));
			if ($urandom_range(1))
				e = -e;
		end else begin
			e = longint'($urandom_range(0, 51472)) - longint'(ANG_PI)
				+ (longint'($urandom_range(0, 2)) - 1) * longint'(ANG_TWO_PI);
		end
		return 16'(g - e);
	endfunction

	task automatic run_random(input int count, input bit push);
		int sent, ticks, tick_pct;
		tick_pct = push ? 3 : 12;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < tick_pct) begin
				ticks = $urandom_range(1, 3);
				repeat (ticks) send_item(FUNC_TIMEOUT, 16'($urandom));
				sent += ticks;
			end else begin
				send_item(FUNC_MEAS, pick_yaw(push));
				sent++;
			end
		end
	endtask

	initial begin
		int p;
		item_ch.valid = 1'b0;
		item_ch.func = FUNC_MEAS;
		item_ch.yaw = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_MAX_RATE;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: goal lands 8000 ahead of the first sample
		load_settings(16'd8192, 16'sd8000, 16'd82, 16'd256, 16'd256);
		send_item(FUNC_TIMEOUT, 16'sh7FFF);
		send_item(FUNC_TIMEOUT, 16'sh8000);
		send_item(FUNC_TIMEOUT, 16'sd0);
		send_item(FUNC_MEAS, 16'sd0);
		send_item(FUNC_MEAS, 16'sh8000);
		send_item(FUNC_MEAS, 16'sh7FFF);
		send_item(FUNC_MEAS, -16'sd17736);
		repeat (3) send_item(FUNC_TIMEOUT, 16'($urandom));
		send_item(FUNC_MEAS, 16'sd7917);
		repeat (2) send_item(FUNC_TIMEOUT, 16'($urandom));
		send_item(FUNC_MEAS, 16'sd7918);
		send_item(FUNC_MEAS, -16'sd18000);
		send_item(FUNC_MEAS, 16'sd15736);
		send_item(FUNC_MEAS, -16'sd9918);
		send_item(FUNC_MEAS, 16'sd0);
		send_item(FUNC_MEAS, 16'sd8000);
		drain_results();

		for (p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 49; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 49; end
				default: begin send_idle_pct = 29; stall_pct = 29; end
			endcase
			case (p)
				0: load_settings(16'hFFFF, -16'sd25736, 16'd0, 16'hFFFF, 16'hFFFF);
				1: load_settings(16'd0, 16'sd25736, 16'd25736, 16'd0, 16'd0);
				2: load_settings(16'd8192, 16'sh7FFF, 16'h8052, 16'd256, 16'd32);
				3: load_settings(16'd1000, 16'sh8000, 16'd300, 16'd512, 16'hFFFF);
				5: load_settings(16'($urandom), 16'($urandom), 16'hFFFF, 16'($urandom),
					16'($urandom));
				default: load_settings(16'($urandom), 16'($urandom),
					{1'($urandom), 15'($urandom_range(0, 2000))}, 16'($urandom), 16'($urandom));
			endcase
			// block the receiver while words keep coming, so the input backs up
			if (p == 2)
				hold_left = HOLD_OFF_CYCLES;
			if (p == 2 || p == 3 || p == 6) begin
				push_sign = 1;
				run_random(PUSH_RUN, 1'b1);
				repeat (3) send_item(FUNC_TIMEOUT, 16'($urandom));
				push_sign = -1;
				run_random(PUSH_RUN, 1'b1);
			end else begin
				run_random(ITEMS_PER_PHASE, 1'b0);
			end
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.expected_cmds.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.expected_cmds.size()));
		$display("Covered %0d yaw samples and %0d timeout ticks over %0d register writes.",
			sb.n_meas, sb.n_tick, sb.n_writes);
		$display("Commands %0d (clamped %0d), goals reached %0d, timeouts %0d, wraps %0d, integral saturations %0d, mismatches %0d.",
			sb.n_cmd, sb.n_clamp, sb.n_reached, sb.n_failed, sb.n_wrap, sb.n_sat,
			sb.mismatches);
		if (sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
src/yprc_pkg.sv
src/yprc_item_if.sv
src/yprc_result_if.sv
src/yprc_cfg_if.sv
src/yprc_cfg.sv
src/yprc_mul.sv
src/yaw_pi_rotation_controller.sv
tb/tb_yaw_pi_rotation_controller.sv
